// ----- rtl/core/hkm_pkg.sv -----
// Shared types, usage codes and the usage-to-matrix ROM for the key matrix mapper.
`default_nettype none

package hkm_pkg;

  localparam int unsigned REPORT_KEYS = 6;
  localparam int unsigned USAGE_W     = 8;
  localparam int unsigned BIT_W       = 6;
  localparam int unsigned MATRIX_W    = 64;
  localparam int unsigned CONSOLE_W   = 3;
  localparam int unsigned IN_DATA_W   = 72;
  localparam int unsigned OUT_DATA_W  = 72;
  // lowest bit of key0 on the request data
  localparam int unsigned KEY_LSB     = 17;

  // Usage codes with a meaning of their own
  localparam logic [USAGE_W-1:0] USAGE_CTRL_L  = 8'hE0;
  localparam logic [USAGE_W-1:0] USAGE_SHIFT_L = 8'hE1;
  localparam logic [USAGE_W-1:0] USAGE_CTRL_R  = 8'hE4;
  localparam logic [USAGE_W-1:0] USAGE_SHIFT_R = 8'hE5;
  localparam logic [USAGE_W-1:0] USAGE_ALT_GR  = 8'hE6;
  localparam logic [USAGE_W-1:0] USAGE_BRK     = 8'h48;
  localparam logic [USAGE_W-1:0] USAGE_START   = 8'h3F;
  localparam logic [USAGE_W-1:0] USAGE_SELECT  = 8'h40;
  localparam logic [USAGE_W-1:0] USAGE_OPTION  = 8'h41;
  localparam logic [USAGE_W-1:0] USAGE_CORE_RST = 8'h42;

  localparam logic [BIT_W-1:0]   ALT_GR_BIT    = 6'h27;
  localparam logic [7:0]         MOD_SHIFT_MASK = 8'h22;
  localparam logic [7:0]         MOD_CTRL_MASK  = 8'h11;
  localparam logic [CONSOLE_W-1:0] CONSOLE_RESET = 3'b111;

  // Opcode carried on tuser
  localparam logic OP_KEY_EVENT = 1'b0;
  localparam logic OP_REPORT    = 1'b1;

  typedef struct packed {
    logic             mapped;
    logic [BIT_W-1:0] bit_idx;
    logic             brk;
  } lane_t;

  typedef struct packed {
    logic                     opcode;
    logic [USAGE_W-1:0]       usage;
    logic                     pressed;
    logic                     mod_shift;
    logic                     mod_ctrl;
  } req_t;

  typedef struct packed {
    logic [MATRIX_W-1:0]  matrix;
    logic                 shift;
    logic                 ctrl;
    logic                 brk;
    logic [CONSOLE_W-1:0] console;
    logic                 core_reset;
  } state_t;

  // {mapped, matrix bit}
  function automatic logic [BIT_W:0] code_rom(input logic [USAGE_W-1:0] u);
    logic [BIT_W:0] e;
    e = '0;
    unique case (u)
      8'h04: e = {1'b1, 6'h3F};  8'h05: e = {1'b1, 6'h15};
      8'h06: e = {1'b1, 6'h12};  8'h07: e = {1'b1, 6'h3A};
      8'h08: e = {1'b1, 6'h2A};  8'h09: e = {1'b1, 6'h38};
      8'h0A: e = {1'b1, 6'h3D};  8'h0B: e = {1'b1, 6'h39};
      8'h0C: e = {1'b1, 6'h0D};  8'h0D: e = {1'b1, 6'h01};
      8'h0E: e = {1'b1, 6'h05};  8'h0F: e = {1'b1, 6'h00};
      8'h10: e = {1'b1, 6'h25};  8'h11: e = {1'b1, 6'h23};
      8'h12: e = {1'b1, 6'h08};  8'h13: e = {1'b1, 6'h0A};
      8'h14: e = {1'b1, 6'h2F};  8'h15: e = {1'b1, 6'h28};
      8'h16: e = {1'b1, 6'h3E};  8'h17: e = {1'b1, 6'h2D};
      8'h18: e = {1'b1, 6'h0B};  8'h19: e = {1'b1, 6'h10};
      8'h1A: e = {1'b1, 6'h2E};  8'h1B: e = {1'b1, 6'h16};
      8'h1C: e = {1'b1, 6'h2B};  8'h1D: e = {1'b1, 6'h17};
      8'h1E: e = {1'b1, 6'h1F};  8'h1F: e = {1'b1, 6'h1E};
      8'h20: e = {1'b1, 6'h1A};  8'h21: e = {1'b1, 6'h18};
      8'h22: e = {1'b1, 6'h1D};  8'h23: e = {1'b1, 6'h1B};
      8'h24: e = {1'b1, 6'h33};  8'h25: e = {1'b1, 6'h35};
      8'h26: e = {1'b1, 6'h30};  8'h27: e = {1'b1, 6'h32};
      8'h28: e = {1'b1, 6'h0C};  8'h29: e = {1'b1, 6'h1C};
      8'h2A: e = {1'b1, 6'h34};  8'h2B: e = {1'b1, 6'h2C};
      8'h2C: e = {1'b1, 6'h21};  8'h2D: e = {1'b1, 6'h36};
      8'h2E: e = {1'b1, 6'h37};  8'h2F: e = {1'b1, 6'h0E};
      8'h30: e = {1'b1, 6'h0F};  8'h31: e = {1'b1, 6'h02};
      8'h32: e = {1'b1, 6'h02};  8'h33: e = {1'b1, 6'h06};
      8'h34: e = {1'b1, 6'h07};  8'h36: e = {1'b1, 6'h20};
      8'h37: e = {1'b1, 6'h22};  8'h38: e = {1'b1, 6'h26};
      8'h39: e = {1'b1, 6'h3C};  8'h3A: e = {1'b1, 6'h03};
      8'h3B: e = {1'b1, 6'h04};  8'h3C: e = {1'b1, 6'h13};
      8'h3D: e = {1'b1, 6'h14};  8'h3E: e = {1'b1, 6'h11};
      8'h54: e = {1'b1, 6'h26};  8'h55: e = {1'b1, 6'h07};
      8'h56: e = {1'b1, 6'h36};  8'h57: e = {1'b1, 6'h06};
      8'h58: e = {1'b1, 6'h0C};  8'h59: e = {1'b1, 6'h1F};
      8'h5A: e = {1'b1, 6'h1E};  8'h5B: e = {1'b1, 6'h1A};
      8'h5C: e = {1'b1, 6'h18};  8'h5D: e = {1'b1, 6'h1D};
      8'h5E: e = {1'b1, 6'h1B};  8'h5F: e = {1'b1, 6'h33};
      8'h60: e = {1'b1, 6'h35};  8'h61: e = {1'b1, 6'h30};
      8'h62: e = {1'b1, 6'h32};  8'h63: e = {1'b1, 6'h22};
      default: e = '0;
    endcase
    return e;
  endfunction

endpackage

`default_nettype wire

// ----- rtl/core/hkm_lane.sv -----
// One lookup lane: usage code to registered matrix bit and break flag.
`default_nettype none

module hkm_lane (
  input  wire logic                        clk,
  input  wire logic                        en,
  input  wire logic [hkm_pkg::USAGE_W-1:0] usage,
  output hkm_pkg::lane_t                   result
);

  logic [hkm_pkg::BIT_W:0] entry;

  assign entry = hkm_pkg::code_rom(usage);

  // ROM holds no entry for zero, break or the modifier range, so those drop out here
  always_ff @(posedge clk) begin
    if (en) begin
      result.mapped  <= entry[hkm_pkg::BIT_W];
      result.bit_idx <= entry[hkm_pkg::BIT_W-1:0];
      result.brk     <= (usage == hkm_pkg::USAGE_BRK);
    end
  end

endmodule

`default_nettype wire

// ----- rtl/core/hkm_merge.sv -----
// Merge stage: combines lane results and applies the request to the held state.
`default_nettype none

module hkm_merge (
  input  wire logic           clk,
  input  wire logic           rst,
  input  wire logic           en,
  input  hkm_pkg::req_t       req,
  input  hkm_pkg::lane_t      lanes [hkm_pkg::REPORT_KEYS],
  output hkm_pkg::state_t     state
);

  hkm_pkg::state_t             state_next;
  logic [hkm_pkg::MATRIX_W-1:0] report_matrix;
  logic                         report_brk;

  always_comb begin
    report_matrix = '0;
    report_brk    = 1'b0;
    for (int i = 0; i < hkm_pkg::REPORT_KEYS; i++) begin
      if (lanes[i].mapped)
        report_matrix = report_matrix
                      | (hkm_pkg::MATRIX_W'(1) << lanes[i].bit_idx);
      report_brk = report_brk | lanes[i].brk;
    end
  end

  always_comb begin
    state_next = state;
    if (req.opcode == hkm_pkg::OP_REPORT) begin
      state_next.matrix = report_matrix;
      state_next.shift  = req.mod_shift;
      state_next.ctrl   = req.mod_ctrl;
      state_next.brk    = report_brk;
    end else begin
      // key event: lane 0 carries the lookup of the event usage
      unique case (req.usage)
        hkm_pkg::USAGE_SHIFT_L, hkm_pkg::USAGE_SHIFT_R: state_next.shift = req.pressed;
        hkm_pkg::USAGE_CTRL_L, hkm_pkg::USAGE_CTRL_R:   state_next.ctrl  = req.pressed;
        hkm_pkg::USAGE_BRK:      state_next.brk        = req.pressed;
        hkm_pkg::USAGE_START:    state_next.console[0] = ~req.pressed;
        hkm_pkg::USAGE_SELECT:   state_next.console[1] = ~req.pressed;
        hkm_pkg::USAGE_OPTION:   state_next.console[2] = ~req.pressed;
        hkm_pkg::USAGE_CORE_RST: state_next.core_reset = req.pressed;
        hkm_pkg::USAGE_ALT_GR:   state_next.matrix[hkm_pkg::ALT_GR_BIT] = req.pressed;
        default: begin
          if (lanes[0].mapped)
            state_next.matrix[lanes[0].bit_idx] = req.pressed;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state.matrix     <= '0;
      state.shift      <= 1'b0;
      state.ctrl       <= 1'b0;
      state.brk        <= 1'b0;
      state.console    <= hkm_pkg::CONSOLE_RESET;
      state.core_reset <= 1'b0;
    end else if (en) begin
      state <= state_next;
    end
  end

endmodule

`default_nettype wire

// ----- rtl/core/hid_to_key_matrix_mapper.sv -----
// Top level of the keyboard usage to key matrix mapper.
// A request passes the lane lookup register, then the merge register.
// Six ROM lanes read a report's keys at once; one request per cycle unless stalled.
// s_axis_tready stays high while a result waits, as long as the lane stage is free.
// Reset (rst, synchronous): matrix and flags clear, console word all released (3'b111).
`default_nettype none

module hid_to_key_matrix_mapper (
  input  wire logic                           clk,
  input  wire logic                           rst,
  input  wire logic                           s_axis_tvalid,
  output      logic                           s_axis_tready,
  // usage[7:0], key_pressed[8], modifiers[16:9], key0..key5[64:17], zero pad[71:65]
  input  wire logic [hkm_pkg::IN_DATA_W-1:0]  s_axis_tdata,
  // opcode[0]
  input  wire logic                           s_axis_tuser,
  output      logic                           m_axis_tvalid,
  input  wire logic                           m_axis_tready,
  // key_matrix[63:0], shift_held[64], ctrl_held[65], break_held[66],
  // console_bits[69:67], core_reset[70], zero pad[71]
  output      logic [hkm_pkg::OUT_DATA_W-1:0] m_axis_tdata
);

  logic            s1_valid;
  logic            out_ready;
  logic            s_accept;
  logic            s1_advance;
  hkm_pkg::req_t   req;
  hkm_pkg::lane_t  lanes [hkm_pkg::REPORT_KEYS];
  hkm_pkg::state_t state;

  logic [hkm_pkg::USAGE_W-1:0] lane_usage [hkm_pkg::REPORT_KEYS];

  assign out_ready     = !m_axis_tvalid || m_axis_tready;
  assign s1_advance    = s1_valid && out_ready;
  assign s_axis_tready = !s1_valid || out_ready;
  assign s_accept      = s_axis_tvalid && s_axis_tready;

  // lane 0 doubles as the lookup for a single key event
  always_comb begin
    for (int i = 0; i < hkm_pkg::REPORT_KEYS; i++)
      lane_usage[i] = s_axis_tdata[hkm_pkg::KEY_LSB + i*hkm_pkg::USAGE_W +: hkm_pkg::USAGE_W];
    if (s_axis_tuser == hkm_pkg::OP_KEY_EVENT)
      lane_usage[0] = s_axis_tdata[hkm_pkg::USAGE_W-1:0];
  end

  for (genvar g = 0; g < hkm_pkg::REPORT_KEYS; g++) begin : g_lane
    hkm_lane u_lane (
      .clk    (clk),
      .en     (s_accept),
      .usage  (lane_usage[g]),
      .result (lanes[g])
    );
  end

  always_ff @(posedge clk) begin
    if (s_accept) begin
      req.opcode    <= s_axis_tuser;
      req.usage     <= s_axis_tdata[7:0];
      req.pressed   <= s_axis_tdata[8];
      req.mod_shift <= |(s_axis_tdata[16:9] & hkm_pkg::MOD_SHIFT_MASK);
      req.mod_ctrl  <= |(s_axis_tdata[16:9] & hkm_pkg::MOD_CTRL_MASK);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid      <= 1'b0;
      m_axis_tvalid <= 1'b0;
    end else begin
      if (s_accept)
        s1_valid <= 1'b1;
      else if (s1_advance)
        s1_valid <= 1'b0;
      if (s1_advance)
        m_axis_tvalid <= 1'b1;
      else if (m_axis_tready)
        m_axis_tvalid <= 1'b0;
    end
  end

  // state changes only when a new result is loaded, so it is the output payload
  hkm_merge u_merge (
    .clk   (clk),
    .rst   (rst),
    .en    (s1_advance),
    .req   (req),
    .lanes (lanes),
    .state (state)
  );

  assign m_axis_tdata = {1'b0, state.core_reset, state.console, state.brk,
                         state.ctrl, state.shift, state.matrix};

endmodule

`default_nettype wire

// ----- rtl/core/hkm_checker.sv -----
// Port-level checks for the key matrix mapper, bound to the top level.
`default_nettype none

module hkm_checker (
  input wire logic                           clk,
  input wire logic                           rst,
  input wire logic                           s_axis_tready,
  input wire logic                           m_axis_tvalid,
  input wire logic                           m_axis_tready,
  input wire logic [hkm_pkg::OUT_DATA_W-1:0] m_axis_tdata
);

  a_reset_clears_valid: assert property (@(posedge clk) rst |=> !m_axis_tvalid)
    else $error("result valid after reset");

  a_stall_holds: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
    else $error("stalled result changed");

  a_idle_state_stable: assert property (@(posedge clk) disable iff (rst)
    !m_axis_tvalid |=> m_axis_tvalid || $stable(m_axis_tdata))
    else $error("state changed without a new result");

  a_no_backpressure_ready: assert property (@(posedge clk) disable iff (rst)
    m_axis_tready |-> s_axis_tready)
    else $error("request side stalled while result side is ready");

  a_pad_zero: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid |-> !m_axis_tdata[hkm_pkg::OUT_DATA_W-1])
    else $error("result pad bit set");

endmodule

bind hid_to_key_matrix_mapper hkm_checker u_hkm_checker (
  .clk           (clk),
  .rst           (rst),
  .s_axis_tready (s_axis_tready),
  .m_axis_tvalid (m_axis_tvalid),
  .m_axis_tready (m_axis_tready),
  .m_axis_tdata  (m_axis_tdata)
);

`default_nettype wire

// ----- tb/tb.sv -----
// Self-checking testbench for the keyboard usage to key matrix mapper.
module tb;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int CYCLE_LIMIT     = 300000;
  localparam int HOLD_OFF_CYCLES = 300;
  localparam int MAX_REPORTED    = 10;

  // Usages with no special meaning here: all four are dropped by the mapper
  localparam logic [hkm_pkg::USAGE_W-1:0] USAGE_NONE  = 8'h00;
  localparam logic [hkm_pkg::USAGE_W-1:0] USAGE_ALT_L = 8'hE2;
  localparam logic [hkm_pkg::USAGE_W-1:0] USAGE_GUI_L = 8'hE3;
  localparam logic [hkm_pkg::USAGE_W-1:0] USAGE_GUI_R = 8'hE7;

  typedef struct packed {
    bit               opcode;
    bit [7:0]         usage;
    bit               pressed;
    bit [7:0]         mods;
    bit [5:0][7:0]    keys;   // keys[0] in the low byte
  } kbd_req_t;

  typedef struct packed {
    bit [63:0] matrix;
    bit        shift;
    bit        ctrl;
    bit        brk;
    bit [2:0]  console;
    bit        core_rst;
  } kb_state_t;

  localparam kb_state_t KB_RESET = '{matrix: '0, shift: 1'b0, ctrl: 1'b0, brk: 1'b0,
                                     console: 3'b111, core_rst: 1'b0};

  logic                  clk;
  logic                  rst = 1'b1;
  logic                  s_axis_tvalid = 1'b0;
  logic                  s_axis_tready;
  // usage[7:0], key_pressed[8], modifiers[16:9], key0..key5[64:17], zero pad[71:65]
  logic [hkm_pkg::IN_DATA_W-1:0]  s_axis_tdata = '0;
  // opcode[0]
  logic                  s_axis_tuser = 1'b0;
  logic                  m_axis_tvalid;
  logic                  m_axis_tready = 1'b0;
  // key_matrix[63:0], shift_held[64], ctrl_held[65], break_held[66],
  // console_bits[69:67], core_reset[70], zero pad[71]
  logic [hkm_pkg::OUT_DATA_W-1:0] m_axis_tdata;

  kb_state_t kb_model = KB_RESET;
  kb_state_t pending_states[$];
  int        mismatches = 0;
  int        cycle_cnt = 0;
  int        src_idle_pct = 0;
  int        sink_stall_pct = 0;
  int        hold_off_asked = 0;
  int        hold_off_granted = 0;
  int        hold_left = 0;

  hid_to_key_matrix_mapper u_top (
    .clk           (clk),
    .rst           (rst),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
  );

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  // Matrix bit of a usage, -1 where the usage has no entry
  function automatic int usage_bit(bit [7:0] u);
    case (u)
      8'h04: return 'h3F; 8'h05: return 'h15; 8'h06: return 'h12; 8'h07: return 'h3A;
      8'h08: return 'h2A; 8'h09: return 'h38; 8'h0A: return 'h3D; 8'h0B: return 'h39;
      8'h0C: return 'h0D; 8'h0D: return 'h01; 8'h0E: return 'h05; 8'h0F: return 'h00;
      8'h10: return 'h25; 8'h11: return 'h23; 8'h12: return 'h08; 8'h13: return 'h0A;
      8'h14: return 'h2F; 8'h15: return 'h28; 8'h16: return 'h3E; 8'h17: return 'h2D;
      8'h18: return 'h0B; 8'h19: return 'h10; 8'h1A: return 'h2E; 8'h1B: return 'h16;
      8'h1C: return 'h2B; 8'h1D: return 'h17; 8'h1E: return 'h1F; 8'h1F: return 'h1E;
      8'h20: return 'h1A; 8'h21: return 'h18; 8'h22: return 'h1D; 8'h23: return 'h1B;
      8'h24: return 'h33; 8'h25: return 'h35; 8'h26: return 'h30; 8'h27: return 'h32;
      8'h28: return 'h0C; 8'h29: return 'h1C; 8'h2A: return 'h34; 8'h2B: return 'h2C;
      8'h2C: return 'h21; 8'h2D: return 'h36; 8'h2E: return 'h37; 8'h2F: return 'h0E;
      8'h30: return 'h0F; 8'h31: return 'h02; 8'h32: return 'h02; 8'h33: return 'h06;
      8'h34: return 'h07; 8'h36: return 'h20; 8'h37: return 'h22; 8'h38: return 'h26;
      8'h39: return 'h3C; 8'h3A: return 'h03; 8'h3B: return 'h04; 8'h3C: return 'h13;
      8'h3D: return 'h14; 8'h3E: return 'h11;
      8'h54: return 'h26; 8'h55: return 'h07; 8'h56: return 'h36; 8'h57: return 'h06;
      8'h58: return 'h0C; 8'h59: return 'h1F; 8'h5A: return 'h1E; 8'h5B: return 'h1A;
      8'h5C: return 'h18; 8'h5D: return 'h1D; 8'h5E: return 'h1B; 8'h5F: return 'h33;
      8'h60: return 'h35; 8'h61: return 'h30; 8'h62: return 'h32; 8'h63: return 'h22;
      default: return -1;
    endcase
  endfunction

  function automatic kb_state_t next_kb_state(kb_state_t s, kbd_req_t r);
    int        b;
    bit [63:0] m;
    bit        brk;
    bit [7:0]  u;
    if (r.opcode == hkm_pkg::OP_REPORT) begin
      m   = '0;
      brk = 1'b0;
      for (int i = 0; i < hkm_pkg::REPORT_KEYS; i++) begin
        u = r.keys[i];
        if (u == USAGE_NONE) continue;
        if (u == hkm_pkg::USAGE_BRK) begin
          brk = 1'b1;
          continue;
        end
        // modifier block is never part of the matrix in a report
        if (u >= hkm_pkg::USAGE_CTRL_L && u <= USAGE_GUI_R) continue;
        b = usage_bit(u);
        if (b >= 0) m[b] = 1'b1;
      end
      s.matrix = m;
      s.brk    = brk;
      s.shift  = |(r.mods & hkm_pkg::MOD_SHIFT_MASK);
      s.ctrl   = |(r.mods & hkm_pkg::MOD_CTRL_MASK);
    end else begin
      case (r.usage)
        hkm_pkg::USAGE_SHIFT_L, hkm_pkg::USAGE_SHIFT_R: s.shift = r.pressed;
        hkm_pkg::USAGE_CTRL_L, hkm_pkg::USAGE_CTRL_R:   s.ctrl = r.pressed;
        hkm_pkg::USAGE_BRK:                    s.brk = r.pressed;
        hkm_pkg::USAGE_START:                  s.console[0] = !r.pressed;
        hkm_pkg::USAGE_SELECT:                 s.console[1] = !r.pressed;
        hkm_pkg::USAGE_OPTION:                 s.console[2] = !r.pressed;
        hkm_pkg::USAGE_CORE_RST:               s.core_rst = r.pressed;
        hkm_pkg::USAGE_ALT_GR:                 s.matrix[hkm_pkg::ALT_GR_BIT] = r.pressed;
        default: begin
          b = usage_bit(r.usage);
          if (b >= 0) s.matrix[b] = r.pressed;
        end
      endcase
    end
    return s;
  endfunction

  function automatic void check_field(string name, longint unsigned want,
                                      longint unsigned got);
    if (want != got) begin
      mismatches++;
      if (mismatches <= MAX_REPORTED)
        $display("%0t: %s mismatch, expected %h, got %h", $realtime, name, want, got);
    end
  endfunction

  // Predicts on every accepted request, checks every accepted result
  always @(posedge clk) begin
    kbd_req_t  req;
    kb_state_t want;
    if (rst) begin
      kb_model = KB_RESET;
      pending_states.delete();
    end else begin
      if (s_axis_tvalid && s_axis_tready) begin
        req.opcode  = s_axis_tuser;
        req.usage   = s_axis_tdata[7:0];
        req.pressed = s_axis_tdata[8];
        req.mods    = s_axis_tdata[16:9];
        req.keys    = s_axis_tdata[64:17];
        kb_model = next_kb_state(kb_model, req);
        pending_states.push_back(kb_model);
      end
      if (m_axis_tvalid && m_axis_tready) begin
        if (pending_states.size() == 0) begin
          mismatches++;
          if (mismatches <= MAX_REPORTED)
            $display("%0t: result %h with nothing outstanding", $realtime, m_axis_tdata);
        end else begin
          want = pending_states.pop_front();
          check_field("key_matrix", want.matrix, m_axis_tdata[63:0]);
          check_field("shift_held", want.shift, m_axis_tdata[64]);
          check_field("ctrl_held", want.ctrl, m_axis_tdata[65]);
          check_field("break_held", want.brk, m_axis_tdata[66]);
          check_field("console_bits", want.console, m_axis_tdata[69:67]);
          check_field("core_reset", want.core_rst, m_axis_tdata[70]);
        end
      end
    end
  end

  // Result side: random stalls plus the occasional long hold-off
  always @(posedge clk) begin
    if (hold_off_asked != hold_off_granted) begin
      hold_off_granted = hold_off_asked;
      hold_left = HOLD_OFF_CYCLES;
    end
    if (hold_left > 0) begin
      hold_left = hold_left - 1;
      m_axis_tready <= 1'b0;
    end else begin
      m_axis_tready <= ($urandom_range(99) >= sink_stall_pct);
    end
  end

  initial begin
    while (cycle_cnt < CYCLE_LIMIT) begin
      @(posedge clk);
      cycle_cnt++;
    end
    $display("*** FAILED ***");
    $finish;
  end

  task automatic send_req(kbd_req_t r);
    while ($urandom_range(99) < src_idle_pct) begin
      s_axis_tvalid <= 1'b0;
      @(posedge clk);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tuser  <= r.opcode;
    s_axis_tdata  <= {7'b0, r.keys, r.mods, r.pressed, r.usage};
    @(posedge clk);
    while (!s_axis_tready) @(posedge clk);
  endtask

  task automatic wait_all_results();
    s_axis_tvalid <= 1'b0;
    @(posedge clk);
    while (pending_states.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  function automatic kbd_req_t key_ev(bit [7:0] u, bit p);
    kbd_req_t r;
    r.opcode  = hkm_pkg::OP_KEY_EVENT;
    r.usage   = u;
    r.pressed = p;
    r.mods    = 8'($urandom_range(255));
    for (int i = 0; i < 6; i++) r.keys[i] = 8'($urandom_range(255));
    return r;
  endfunction

  function automatic kbd_req_t rep(bit [7:0] mods, bit [7:0] k0, bit [7:0] k1,
                                   bit [7:0] k2, bit [7:0] k3, bit [7:0] k4,
                                   bit [7:0] k5);
    kbd_req_t r;
    r.opcode  = hkm_pkg::OP_REPORT;
    r.usage   = 8'($urandom_range(255));
    r.pressed = 1'($urandom_range(1));
    r.mods    = mods;
    r.keys    = {k5, k4, k3, k2, k1, k0};
    return r;
  endfunction

  function automatic bit [7:0] pick_usage();
    bit [7:0] specials[14] = '{hkm_pkg::USAGE_SHIFT_L, hkm_pkg::USAGE_SHIFT_R,
                               hkm_pkg::USAGE_CTRL_L, hkm_pkg::USAGE_CTRL_R,
                               hkm_pkg::USAGE_BRK, hkm_pkg::USAGE_START,
                               hkm_pkg::USAGE_SELECT, hkm_pkg::USAGE_OPTION,
                               hkm_pkg::USAGE_CORE_RST, hkm_pkg::USAGE_ALT_GR,
                               USAGE_ALT_L, USAGE_GUI_L, USAGE_GUI_R, USAGE_NONE};
    int sel;
    sel = $urandom_range(99);
    if (sel < 55) return 8'($urandom_range(8'h63, 8'h04));
    if (sel < 80) return specials[$urandom_range(13)];
    return 8'($urandom_range(255));
  endfunction

  function automatic bit [7:0] pick_report_key();
    int sel;
    sel = $urandom_range(99);
    if (sel < 30) return USAGE_NONE;
    if (sel < 75) return 8'($urandom_range(8'h63, 8'h04));
    if (sel < 80) return hkm_pkg::USAGE_BRK;
    return 8'($urandom_range(255));
  endfunction

  function automatic kbd_req_t rand_req();
    kbd_req_t r;
    if ($urandom_range(99) < 65) begin
      r = key_ev(pick_usage(), $urandom_range(99) < 55);
    end else begin
      r = rep($urandom_range(3) == 0 ? 8'h00 : 8'($urandom_range(255)),
              pick_report_key(), pick_report_key(), pick_report_key(),
              pick_report_key(), pick_report_key(), pick_report_key());
    end
    return r;
  endfunction

  task automatic test_directed();
    src_idle_pct   = 0;
    sink_stall_pct = 0;
    send_req(key_ev(USAGE_NONE, 1'b1));
    send_req(key_ev(hkm_pkg::USAGE_SHIFT_L, 1'b1));
    send_req(key_ev(hkm_pkg::USAGE_CTRL_R, 1'b1));
    send_req(key_ev(hkm_pkg::USAGE_BRK, 1'b1));
    send_req(key_ev(hkm_pkg::USAGE_START, 1'b1));
    send_req(key_ev(hkm_pkg::USAGE_SELECT, 1'b1));
    send_req(key_ev(hkm_pkg::USAGE_OPTION, 1'b1));
    send_req(key_ev(hkm_pkg::USAGE_CORE_RST, 1'b1));
    send_req(key_ev(hkm_pkg::USAGE_ALT_GR, 1'b1));
    send_req(key_ev(8'h04, 1'b1));   // top matrix bit
    send_req(key_ev(8'h0F, 1'b1));   // bottom matrix bit
    // two usages on one bit: releasing the other clears it
    send_req(key_ev(8'h31, 1'b1));
    send_req(key_ev(8'h32, 1'b0));
    send_req(key_ev(8'hFF, 1'b1));
    send_req(key_ev(USAGE_GUI_R, 1'b1));
    send_req(key_ev(USAGE_ALT_L, 1'b1));
    send_req(key_ev(hkm_pkg::USAGE_SHIFT_R, 1'b0));
    send_req(key_ev(hkm_pkg::USAGE_CTRL_L, 1'b0));
    send_req(key_ev(hkm_pkg::USAGE_START, 1'b0));
    send_req(key_ev(hkm_pkg::USAGE_CORE_RST, 1'b0));
    // reports leave console and reset request alone
    send_req(rep(8'hFF, hkm_pkg::USAGE_BRK, hkm_pkg::USAGE_ALT_GR, 8'h04, 8'h04,
                 8'h31, 8'h32));
    send_req(rep(8'h22, 8'hFF, hkm_pkg::USAGE_CTRL_L, 8'h63, 8'h3E, USAGE_NONE,
                 USAGE_NONE));
    send_req(rep(8'h11, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00));
    send_req(rep(8'h00, 8'h0F, 8'h63, 8'h62, 8'h61, 8'h60, 8'h54));
    send_req(key_ev(hkm_pkg::USAGE_ALT_GR, 1'b0));
    wait_all_results();
  endtask

  task automatic test_random(int n, int src_idle, int sink_stall);
    src_idle_pct   = src_idle;
    sink_stall_pct = sink_stall;
    for (int i = 0; i < n; i++) send_req(rand_req());
    wait_all_results();
  endtask

  // Receiver holds off while requests keep coming, so the input stalls
  task automatic test_hold_off();
    src_idle_pct   = 0;
    sink_stall_pct = 0;
    hold_off_asked++;
    for (int i = 0; i < 60; i++) send_req(rand_req());
    wait_all_results();
  endtask

  initial begin
    repeat (9) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    test_directed();
    test_random(400, 0, 0);
    test_random(400, 83, 0);
    test_random(400, 0, 83);
    test_hold_off();
    test_random(400, 30, 30);
    repeat (10) @(posedge clk);
    if (mismatches == 0 && pending_states.size() == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule

// ----- filelist.f -----
rtl/core/hkm_pkg.sv
rtl/core/hkm_lane.sv
rtl/core/hkm_merge.sv
rtl/core/hid_to_key_matrix_mapper.sv
rtl/core/hkm_checker.sv
tb/tb.sv
